### src/tce_pkg.sv
// tce_pkg: shared types and constants of the transitive closure engine.
// No dependencies; imported by transitive_closure_engine, tce_cfg and tce_ctrl.
package tce_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FLAG = 1'b1;

  // configuration space
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam logic        REG_NODE_COUNT = 1'b0;   // register index, paddr[2]
  localparam logic [5:0]  NODE_COUNT_RST = 6'd32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  source_node;
    logic [4:0]  target_node;
    logic [31:0] done_mask;
  } tce_req_t;

  typedef struct packed {
    logic        status;
    logic        reaches;
    logic [31:0] ancestor_mask;
    logic        all_satisfied;
    logic        cycle_found;
  } tce_rsp_t;

endpackage

### src/transitive_closure_engine.sv
// transitive_closure_engine: top level of the reachability engine.
// Depends on tce_pkg, tce_cfg, tce_ctrl and tce_rowmem.
//
// Directed relation over up to MAX_NODES nodes, edges in one row memory, the
// Warshall closure in a second. A request is taken when start is high and
// busy low; its result sits on rsp_o for exactly one cycle with res_valid_o
// high and must be captured then, the engine cannot be held off. The active
// node count is node_count limited to MAX_NODES. Clear and flagged requests
// give the result the cycle after acceptance; add writes the edge row in S_ADD;
// close or query with an unchanged relation runs S_SCAN and S_SFIN (one closure
// row read per cycle for the cycle/ancestor scan); after an edge change or a
// node_count write it first rebuilds the closure (S_COPY, then S_PIV and S_ROW
// per pivot), one row OR per cycle through the single read/write port pair of
// the closure memory. A new request may be accepted in the same cycle that the
// previous result is presented. The user must write node_count through the APB
// port only while busy is low; the block itself does not enforce this.
module transitive_closure_engine import tce_pkg::*; #(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request / result
  input  logic                  start,
  input  tce_req_t              req_i,
  output logic                  busy,
  output logic                  res_valid_o,
  output tce_rsp_t              rsp_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned IW = $clog2(MAX_NODES);

  logic [5:0]           node_count;
  logic                 count_wr;
  logic                 e_clr, e_we, c_clr, c_we;
  logic [IW-1:0]        e_waddr, e_raddr, c_waddr, c_raddr;
  logic [MAX_NODES-1:0] e_wdata, e_rdata, c_wdata, c_rdata;

  tce_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .node_count_o (node_count),
    .count_wr_o   (count_wr)
  );

  // sequencer: edge add, closure rebuild, result scan
  tce_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i      (start),
    .req_i,
    .busy_o       (busy),
    .res_valid_o,
    .rsp_o,
    .node_count_i (node_count),
    .count_wr_i   (count_wr),
    .e_clr_o      (e_clr),
    .e_we_o       (e_we),
    .e_waddr_o    (e_waddr),
    .e_wdata_o    (e_wdata),
    .e_raddr_o    (e_raddr),
    .e_rdata_i    (e_rdata),
    .c_clr_o      (c_clr),
    .c_we_o       (c_we),
    .c_waddr_o    (c_waddr),
    .c_wdata_o    (c_wdata),
    .c_raddr_o    (c_raddr),
    .c_rdata_i    (c_rdata)
  );

  // edge rows: row a bit b set when a directly precedes b
  tce_rowmem #(
    .DEPTH (MAX_NODES),
    .WIDTH (MAX_NODES)
  ) u_edge_mem (
    .clk_i,
    .rst_ni,
    .clr_i   (e_clr),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // closure rows: row a bit b set when a reaches b
  tce_rowmem #(
    .DEPTH (MAX_NODES),
    .WIDTH (MAX_NODES)
  ) u_closure_mem (
    .clk_i,
    .rst_ni,
    .clr_i   (c_clr),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

endmodule

### src/tce_rowmem.sv
// tce_rowmem: one-port-write, one-port-read row memory with registered read.
// Per-row valid bits give all-zero reset and a clear of all rows at once. No dependencies.
module tce_rowmem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [DEPTH-1:0] valid_q;
  logic             rvalid_q;
  logic             fwd;

  // write-first: a read of the row being written sees the new data
  assign fwd = we_i && (waddr_i == raddr_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (fwd) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= fwd ? 1'b1 : valid_q[raddr_i];
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

### src/tce_cfg.sv
// tce_cfg: APB register slave holding node_count.
// Depends on tce_pkg.
module tce_cfg import tce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [5:0]            node_count_o,
  output logic                  count_wr_o
);

  logic [5:0] node_count_q, node_count_d;
  logic       hit;

  assign pready     = 1'b1;
  assign hit        = (paddr[2] == REG_NODE_COUNT);
  assign count_wr_o = psel && penable && pwrite && hit;

  always_comb begin
    node_count_d = node_count_q;
    if (count_wr_o) begin
      node_count_d = pwdata[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else begin
      node_count_q <= node_count_d;
    end
  end

  assign prdata       = hit ? {26'd0, node_count_q} : 32'd0;
  assign node_count_o = node_count_q;

endmodule

### src/tce_ctrl.sv
// tce_ctrl: request sequencer; edge update, Warshall row sweep and result scan.
// Depends on tce_pkg; drives the edge and closure row memories.
module tce_ctrl import tce_pkg::*; #(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  tce_req_t                     req_i,
  output logic                         busy_o,
  output logic                         res_valid_o,
  output tce_rsp_t                     rsp_o,
  input  logic [5:0]                   node_count_i,
  input  logic                         count_wr_i,
  // edge memory
  output logic                         e_clr_o,
  output logic                         e_we_o,
  output logic [$clog2(MAX_NODES)-1:0] e_waddr_o,
  output logic [MAX_NODES-1:0]         e_wdata_o,
  output logic [$clog2(MAX_NODES)-1:0] e_raddr_o,
  input  logic [MAX_NODES-1:0]         e_rdata_i,
  // closure memory
  output logic                         c_clr_o,
  output logic                         c_we_o,
  output logic [$clog2(MAX_NODES)-1:0] c_waddr_o,
  output logic [MAX_NODES-1:0]         c_wdata_o,
  output logic [$clog2(MAX_NODES)-1:0] c_raddr_o,
  input  logic [MAX_NODES-1:0]         c_rdata_i
);

  localparam int unsigned W  = MAX_NODES;
  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned NW = 7;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_PIV  = 3'd3;
  localparam logic [2:0] S_ROW  = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_SFIN = 3'd6;

  logic [2:0]    state_q, state_d;
  logic          stale_q, stale_d;
  logic          rvalid_q, rvalid_d;
  tce_rsp_t      rsp_q, rsp_d;
  tce_req_t      req_q, req_d;
  logic [IW-1:0] i_q, i_d, k_q, k_d;
  logic          wb_v_q, wb_v_d, wb_copy_q, wb_copy_d;
  logic [IW-1:0] wb_a_q, wb_a_d, wb_k_q, wb_k_d;
  logic          sc_v_q, sc_v_d;
  logic [IW-1:0] sc_a_q, sc_a_d;
  logic [W-1:0]  pivot_q, pivot_d;
  logic [W-1:0]  anc_q, anc_d;
  logic          cyc_q, cyc_d;

  logic [NW-1:0] n_w;
  logic [IW-1:0] last_w;
  logic [W-1:0]  act_mask;
  logic          accept, in_range;
  logic [IW-1:0] src_ix, dst_ix;
  logic [W+31:0] anc_ext, done_ext;

  // active count, limited to the array depth
  assign n_w = ({1'b0, node_count_i} > NW'(MAX_NODES)) ? NW'(MAX_NODES)
                                                       : {1'b0, node_count_i};
  assign last_w = IW'(n_w - NW'(1));

  always_comb begin
    for (int j = 0; j < W; j++) begin
      act_mask[j] = (NW'(j) < n_w);
    end
  end

  assign accept   = start_i && (state_q == S_IDLE);
  assign in_range = ({2'b00, req_i.source_node} < n_w)
                 && ({2'b00, req_i.target_node} < n_w);
  assign src_ix   = IW'(req_q.source_node);
  assign dst_ix   = IW'(req_q.target_node);

  // scan accumulator: one closure row per cycle
  always_comb begin
    anc_d = anc_q;
    cyc_d = cyc_q;
    if (state_q == S_IDLE) begin
      anc_d = '0;
      cyc_d = 1'b0;
    end else if (sc_v_q) begin
      anc_d[sc_a_q] = c_rdata_i[dst_ix];
      cyc_d         = cyc_q | c_rdata_i[sc_a_q];
    end
  end

  assign anc_ext  = {32'd0, anc_d};
  assign done_ext = {{W{1'b0}}, req_q.done_mask};

  // closure write-back stage
  always_comb begin
    c_we_o    = wb_v_q;
    c_waddr_o = wb_a_q;
    if (wb_copy_q) begin
      c_wdata_o = e_rdata_i & act_mask;
    end else if (c_rdata_i[wb_k_q]) begin
      c_wdata_o = c_rdata_i | pivot_q;
    end else begin
      c_wdata_o = c_rdata_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    stale_d   = stale_q;
    rvalid_d  = 1'b0;
    rsp_d     = rsp_q;
    req_d     = req_q;
    i_d       = i_q;
    k_d       = k_q;
    wb_v_d    = 1'b0;
    wb_copy_d = wb_copy_q;
    wb_a_d    = wb_a_q;
    wb_k_d    = wb_k_q;
    sc_v_d    = 1'b0;
    sc_a_d    = sc_a_q;
    pivot_d   = pivot_q;
    e_clr_o   = 1'b0;
    c_clr_o   = 1'b0;
    e_we_o    = 1'b0;
    e_waddr_o = src_ix;
    e_wdata_o = e_rdata_i | (W'(1) << dst_ix);
    e_raddr_o = i_q;
    c_raddr_o = i_q;

    if (count_wr_i) begin
      stale_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        rsp_d = '0;
        i_d   = '0;
        k_d   = '0;
        if (accept) begin
          req_d = req_i;
          unique case (req_i.operation)
            OP_CLEAR: begin
              e_clr_o  = 1'b1;
              c_clr_o  = 1'b1;
              stale_d  = 1'b0;
              rvalid_d = 1'b1;
            end
            OP_ADD: begin
              if (!in_range) begin
                rsp_d.status = ST_FLAG;
                rvalid_d     = 1'b1;
              end else begin
                e_raddr_o = IW'(req_i.source_node);
                state_d   = S_ADD;
              end
            end
            OP_CLOSE: begin
              if (n_w == '0) begin
                stale_d  = 1'b0;
                rvalid_d = 1'b1;
              end else if (stale_q) begin
                state_d = S_COPY;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_QUERY: begin
              if (!in_range) begin
                rsp_d.status = ST_FLAG;
                rvalid_d     = 1'b1;
              end else if (stale_q) begin
                state_d = S_COPY;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_ADD: begin
        e_we_o   = 1'b1;
        stale_d  = 1'b1;
        rvalid_d = 1'b1;
        state_d  = S_IDLE;
      end

      // masked copy of the edge rows into the closure memory
      S_COPY: begin
        wb_v_d    = 1'b1;
        wb_copy_d = 1'b1;
        wb_a_d    = i_q;
        if (i_q == last_w) begin
          i_d     = '0;
          k_d     = '0;
          state_d = S_PIV;
        end else begin
          i_d = i_q + IW'(1);
        end
      end

      S_PIV: begin
        c_raddr_o = k_q;
        i_d       = '0;
        state_d   = S_ROW;
      end

      // one row OR per cycle; pivot row arrives in the first cycle
      S_ROW: begin
        if (i_q == '0) begin
          pivot_d = c_rdata_i;
        end
        wb_v_d    = 1'b1;
        wb_copy_d = 1'b0;
        wb_a_d    = i_q;
        wb_k_d    = k_q;
        if (i_q == last_w) begin
          i_d = '0;
          if (k_q == last_w) begin
            stale_d = 1'b0;
            state_d = S_SCAN;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = S_PIV;
          end
        end else begin
          i_d = i_q + IW'(1);
        end
      end

      S_SCAN: begin
        sc_v_d = 1'b1;
        sc_a_d = i_q;
        if (i_q == last_w) begin
          state_d = S_SFIN;
        end else begin
          i_d = i_q + IW'(1);
        end
      end

      S_SFIN: begin
        rsp_d             = '0;
        rsp_d.cycle_found = cyc_d;
        if (req_q.operation == OP_QUERY) begin
          rsp_d.reaches       = anc_d[src_ix];
          rsp_d.ancestor_mask = anc_ext[31:0];
          rsp_d.all_satisfied = ((anc_ext & ~done_ext) == '0);
        end
        rvalid_d = 1'b1;
        state_d  = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      stale_q  <= 1'b0;
      rvalid_q <= 1'b0;
      wb_v_q   <= 1'b0;
      sc_v_q   <= 1'b0;
      i_q      <= '0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      stale_q  <= stale_d;
      rvalid_q <= rvalid_d;
      wb_v_q   <= wb_v_d;
      sc_v_q   <= sc_v_d;
      i_q      <= i_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q     <= rsp_d;
    req_q     <= req_d;
    wb_copy_q <= wb_copy_d;
    wb_a_q    <= wb_a_d;
    wb_k_q    <= wb_k_d;
    sc_a_q    <= sc_a_d;
    pivot_q   <= pivot_d;
    anc_q     <= anc_d;
    cyc_q     <= cyc_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = rvalid_q;
  assign rsp_o       = rsp_q;

endmodule
